// ----- rtl/deflate_fixed_huffman_compressor_unit_defines.svh -----
// Assertion macros shared by the compressor RTL.
// Uses the clk and rst names of the module that expands them.
`ifndef DEFLATE_FIXED_HUFFMAN_COMPRESSOR_UNIT_DEFINES_SVH
`define DEFLATE_FIXED_HUFFMAN_COMPRESSOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DFHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DFHC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DFHC_ASSERT(lbl, prop, msg)
`define DFHC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/dfhc_pkg.sv -----
// Package for the fixed Huffman DEFLATE compressor: constants, types,
// code tables and symbol coding. No dependencies.
`default_nettype none
package dfhc_pkg;

  localparam int WINDOW_SIZE_DEF   = 32768;
  localparam int HASH_BITS_DEF     = 15;
  localparam int HISTORY_DEPTH_DEF = 65536;

  localparam logic [31:0] HASH_MULT     = 32'd2654435761;
  localparam logic [8:0]  MAX_MATCH     = 9'd258;
  localparam logic [8:0]  MIN_MATCH     = 9'd3;
  localparam logic [31:0] LOOKAHEAD     = 32'd260;
  localparam logic [7:0]  CHAIN_LIMIT_RST = 8'd64;
  localparam logic [15:0] SHORT_DIST_RST  = 16'd1024;
  localparam int CMD_FIFO_DEPTH = 4;
  localparam int OUT_FIFO_DEPTH = 8;
  localparam int ACC_W = 39;
  localparam int CNT_W = 6;
  localparam int PADDR_W = 3;

  // register index taken from paddr[2]
  localparam logic REG_CHAIN_LIMIT = 1'b0;
  localparam logic REG_SHORT_DIST  = 1'b1;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic        drain;
    logic [31:0] stop_pos;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [8:0] code;
    logic [3:0] nbits;
  } sym_bits_t;

  typedef enum logic [4:0] {
    BK_CLEAR, BK_IDLE, BK_RD0, BK_RD1, BK_RD2, BK_HASH, BK_HEAD, BK_HEADQ,
    BK_WCHK, BK_WPRE, BK_WCMP, BK_WNEXT, BK_WLINK, BK_DEC, BK_PLEN, BK_PLEX,
    BK_PDIS, BK_PDEX, BK_PLIT, BK_PEOB, BK_FLUSH, BK_ICHK, BK_IHEAD, BK_IWR
  } bk_state_t;

  function automatic logic [8:0] len_base(input logic [4:0] i);
    logic [8:0] r;
    case (i)
      5'd0: r = 9'd3;    5'd1: r = 9'd4;    5'd2: r = 9'd5;    5'd3: r = 9'd6;
      5'd4: r = 9'd7;    5'd5: r = 9'd8;    5'd6: r = 9'd9;    5'd7: r = 9'd10;
      5'd8: r = 9'd11;   5'd9: r = 9'd13;   5'd10: r = 9'd15;  5'd11: r = 9'd17;
      5'd12: r = 9'd19;  5'd13: r = 9'd23;  5'd14: r = 9'd27;  5'd15: r = 9'd31;
      5'd16: r = 9'd35;  5'd17: r = 9'd43;  5'd18: r = 9'd51;  5'd19: r = 9'd59;
      5'd20: r = 9'd67;  5'd21: r = 9'd83;  5'd22: r = 9'd99;  5'd23: r = 9'd115;
      5'd24: r = 9'd131; 5'd25: r = 9'd163; 5'd26: r = 9'd195; 5'd27: r = 9'd227;
      default: r = 9'd258;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] len_extra(input logic [4:0] i);
    logic [3:0] r;
    if (i < 5'd8 || i > 5'd27) r = 4'd0;
    else r = {1'b0, i[4:2]} - 4'd1;
    return r;
  endfunction

  function automatic logic [15:0] dist_base(input logic [4:0] i);
    logic [15:0] r;
    case (i)
      5'd0: r = 16'd1;      5'd1: r = 16'd2;      5'd2: r = 16'd3;
      5'd3: r = 16'd4;      5'd4: r = 16'd5;      5'd5: r = 16'd7;
      5'd6: r = 16'd9;      5'd7: r = 16'd13;     5'd8: r = 16'd17;
      5'd9: r = 16'd25;     5'd10: r = 16'd33;    5'd11: r = 16'd49;
      5'd12: r = 16'd65;    5'd13: r = 16'd97;    5'd14: r = 16'd129;
      5'd15: r = 16'd193;   5'd16: r = 16'd257;   5'd17: r = 16'd385;
      5'd18: r = 16'd513;   5'd19: r = 16'd769;   5'd20: r = 16'd1025;
      5'd21: r = 16'd1537;  5'd22: r = 16'd2049;  5'd23: r = 16'd3073;
      5'd24: r = 16'd4097;  5'd25: r = 16'd6145;  5'd26: r = 16'd8193;
      5'd27: r = 16'd12289; 5'd28: r = 16'd16385;
      default: r = 16'd24577;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] dist_extra(input logic [4:0] i);
    logic [3:0] r;
    if (i < 5'd4) r = 4'd0;
    else r = i[4:1] - 4'd1;
    return r;
  endfunction

  // 258 and above takes symbol 285 (index 28)
  function automatic logic [4:0] len_index(input logic [8:0] len);
    logic [4:0] idx;
    logic [9:0] top;
    idx = 5'd28;
    if (len < MAX_MATCH) begin
      for (int i = 27; i >= 0; i--) begin
        top = {1'b0, len_base(5'(i))} + (10'd1 << len_extra(5'(i))) - 10'd1;
        if ({1'b0, len} <= top) idx = 5'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [4:0] dist_index(input logic [15:0] d);
    logic [4:0] idx;
    logic [16:0] top;
    idx = 5'd29;
    for (int i = 28; i >= 0; i--) begin
      top = {1'b0, dist_base(5'(i))} + (17'd1 << dist_extra(5'(i))) - 17'd1;
      if ({1'b0, d} <= top) idx = 5'(i);
    end
    return idx;
  endfunction

  // fixed literal/length code, bit-reversed for LSB-first packing
  function automatic sym_bits_t sym_code(input logic [8:0] sym);
    sym_bits_t r;
    logic [8:0] v;
    logic [8:0] rev;
    if (sym <= 9'd143) begin
      v = 9'h030 + sym;           r.nbits = 4'd8;
    end else if (sym <= 9'd255) begin
      v = 9'h190 + (sym - 9'd144); r.nbits = 4'd9;
    end else if (sym <= 9'd279) begin
      v = sym - 9'd256;           r.nbits = 4'd7;
    end else begin
      v = 9'h0C0 + (sym - 9'd280); r.nbits = 4'd8;
    end
    for (int j = 0; j < 9; j++) rev[j] = v[8-j];
    r.code = rev >> (4'd9 - r.nbits);
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/dfhc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dfhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/dfhc_fifo.sv -----
// Small register FIFO used for the command queue and the output queue.
// No dependencies.
`default_nettype none
module dfhc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0] wr_ptr;
  logic [AW:0] rd_ptr;

  assign empty = (wr_ptr == rd_ptr);
  assign full  = (wr_ptr[AW] != rd_ptr[AW]) && (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]);
  assign rdata = mem[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr[AW-1:0]] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/dfhc_front.sv -----
// Front end: takes input words, stores bytes in the history and queues
// commands for the back end. Depends on dfhc_pkg.
`default_nettype none
module dfhc_front #(
  parameter int HISTORY_DEPTH = 65536
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic                             command,
  input  wire logic [7:0]                       data_byte,
  input  wire logic                             clearing,
  output dfhc_pkg::cmd_t                        q_word,
  output logic                                  q_push,
  input  wire logic                             q_full,
  output logic                                  hist_we,
  output logic      [$clog2(HISTORY_DEPTH)-1:0] hist_waddr,
  output logic      [7:0]                       hist_wdata
);
  import dfhc_pkg::*;

  logic [31:0] bytes_received;
  logic        input_ended;
  logic        accept;
  logic        store;

  assign full   = q_full || clearing;
  assign accept = push && !full;
  // pushes after a drain or with the counter saturated are dropped
  assign store  = accept && (command == CMD_PUSH) && !input_ended &&
                  (bytes_received != 32'hFFFF_FFFF);

  assign hist_we    = store;
  assign hist_waddr = bytes_received[$clog2(HISTORY_DEPTH)-1:0];
  assign hist_wdata = data_byte;

  assign q_push = store || (accept && (command == CMD_DRAIN));
  always_comb begin
    q_word.drain    = command;
    q_word.stop_pos = (command == CMD_DRAIN) ? bytes_received : bytes_received + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_received <= '0;
      input_ended    <= 1'b0;
    end else begin
      if (store) bytes_received <= bytes_received + 32'd1;
      if (accept && (command == CMD_DRAIN)) input_ended <= 1'b1;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/dfhc_back.sv -----
// Back end: match search over hash chains, token coding, bit packing and
// chain insertion. Depends on dfhc_pkg, dfhc_ram and the assertion header.
`default_nettype none
`include "deflate_fixed_huffman_compressor_unit_defines.svh"
module dfhc_back #(
  parameter int WINDOW_SIZE   = 32768,
  parameter int HASH_BITS     = 15,
  parameter int HISTORY_DEPTH = 65536
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire dfhc_pkg::cmd_t                   cmd_word,
  input  wire logic                             cmd_empty,
  output logic                                  cmd_pop,
  output logic      [$clog2(HISTORY_DEPTH)-1:0] hist_addr_a,
  output logic      [$clog2(HISTORY_DEPTH)-1:0] hist_addr_b,
  input  wire logic [7:0]                       hist_data_a,
  input  wire logic [7:0]                       hist_data_b,
  input  wire logic [7:0]                       chain_limit,
  input  wire logic [15:0]                      short_dist,
  output logic                                  out_push,
  output dfhc_pkg::out_word_t                   out_word,
  input  wire logic                             out_full,
  output logic                                  clearing
);
  import dfhc_pkg::*;

  localparam int HAW = $clog2(HISTORY_DEPTH);
  localparam int WAW = $clog2(WINDOW_SIZE);
  localparam int DW  = WAW + 1;

  bk_state_t st, st_next;

  logic [31:0]      epos, stop, cand, q;
  logic             done, ok, pad;
  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic [8:0]       maxl, best, mlen, ins_left;
  logic [DW-1:0]    bd;
  logic [7:0]       chain, b0, b1, b2;
  logic [HASH_BITS-1:0] h, clr_addr;
  logic [4:0]       len_idx, dist_idx;

  logic [32:0] head_rdata, link_rdata;
  logic        head_we;
  logic [HASH_BITS-1:0] head_waddr;
  logic [32:0] head_wdata;

  logic [31:0] rd_a_pos, rd_b_pos, rem, d_cur, prod;
  logic        near_end, ins_end, walk_stop, eq, take_best, is_match;
  logic [8:0]  ln1, cmp_len;
  logic [12:0] put_val;
  logic [3:0]  put_n;
  logic        do_put;
  sym_bits_t   sb;

  dfhc_ram #(.WIDTH(33), .DEPTH(1 << HASH_BITS)) u_heads (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(h), .rdata(head_rdata)
  );

  dfhc_ram #(.WIDTH(33), .DEPTH(WINDOW_SIZE)) u_links (
    .clk(clk), .we(st == BK_IWR), .waddr(q[WAW-1:0]), .wdata(head_rdata),
    .raddr(cand[WAW-1:0]), .rdata(link_rdata)
  );

  assign clearing    = (st == BK_CLEAR);
  assign hist_addr_a = rd_a_pos[HAW-1:0];
  assign hist_addr_b = rd_b_pos[HAW-1:0];

  assign head_we    = (st == BK_CLEAR) || (st == BK_IWR);
  assign head_waddr = (st == BK_CLEAR) ? clr_addr : h;
  assign head_wdata = (st == BK_CLEAR) ? 33'd0 : {1'b1, q};

  assign rem      = stop - epos;
  assign near_end = ({1'b0, epos} + 33'd3) > {1'b0, stop};
  assign ins_end  = ({1'b0, q} + 33'd3) > {1'b0, stop};
  assign d_cur    = epos - cand;
  assign walk_stop = !ok || (chain >= chain_limit) || (cand >= epos) ||
                     (d_cur > 32'(WINDOW_SIZE));
  assign eq       = (hist_data_a == hist_data_b);
  assign ln1      = mlen + 9'd1;
  assign cmp_len  = eq ? ln1 : mlen;
  assign take_best = (cmp_len >= MIN_MATCH) && (cmp_len > best);
  assign is_match = (best >= MIN_MATCH) &&
                    !((best == MIN_MATCH) && ({1'b0, bd} > 17'(short_dist)));
  assign prod     = {8'd0, b0, b1, b2} * HASH_MULT;

  always_ff @(posedge clk) begin
    if (rst) st <= BK_CLEAR;
    else     st <= st_next;
  end

  always_comb begin
    st_next  = st;
    cmd_pop  = 1'b0;
    out_push = 1'b0;
    out_word = '{data: acc[7:0], last: 1'b0};
    rd_a_pos = cand + 32'(best);
    rd_b_pos = epos + 32'(best);
    do_put   = 1'b0;
    put_val  = '0;
    put_n    = '0;
    sb       = sym_code(9'd257 + 9'(len_idx));
    case (st)
      BK_CLEAR: if (clr_addr == {HASH_BITS{1'b1}}) st_next = BK_IDLE;
      BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (!done) begin
            if (cmd_word.drain == CMD_PUSH) begin
              if ((cmd_word.stop_pos - epos) >= LOOKAHEAD) st_next = BK_RD0;
            end else if (epos < cmd_word.stop_pos) begin
              st_next = BK_RD0;
            end else begin
              st_next = BK_PEOB;
            end
          end
        end
      end
      BK_RD0: begin
        rd_a_pos = epos;
        rd_b_pos = epos + 32'd1;
        st_next  = BK_RD1;
      end
      BK_RD1: begin
        rd_a_pos = epos + 32'd2;
        st_next  = BK_RD2;
      end
      BK_RD2:   st_next = near_end ? BK_DEC : BK_HASH;
      BK_HASH:  st_next = BK_HEAD;
      BK_HEAD:  st_next = BK_HEADQ;
      BK_HEADQ: st_next = BK_WCHK;
      BK_WCHK: begin
        // with no match yet this reads index 0 and starts the full compare
        if (walk_stop)          st_next = BK_DEC;
        else if (best == 9'd0)  st_next = BK_WCMP;
        else                    st_next = BK_WPRE;
      end
      BK_WPRE: begin
        rd_a_pos = cand;
        rd_b_pos = epos;
        st_next  = eq ? BK_WCMP : BK_WNEXT;
      end
      BK_WCMP: begin
        rd_a_pos = cand + 32'(ln1);
        rd_b_pos = epos + 32'(ln1);
        if (!(eq && (ln1 < maxl))) begin
          if (take_best && (cmp_len == maxl)) st_next = BK_DEC;
          else                                st_next = BK_WNEXT;
        end
      end
      BK_WNEXT: st_next = BK_WLINK;
      BK_WLINK: st_next = BK_WCHK;
      BK_DEC:   st_next = is_match ? BK_PLEN : BK_PLIT;
      BK_PLEN: begin
        do_put  = 1'b1;
        put_val = 13'(sb.code);
        put_n   = sb.nbits;
        st_next = BK_PLEX;
      end
      BK_PLEX: begin
        do_put  = 1'b1;
        put_val = 13'(best - len_base(len_idx));
        put_n   = len_extra(len_idx);
        st_next = BK_PDIS;
      end
      BK_PDIS: begin
        do_put  = 1'b1;
        put_val = {8'd0, dist_idx[0], dist_idx[1], dist_idx[2], dist_idx[3], dist_idx[4]};
        put_n   = 4'd5;
        st_next = BK_PDEX;
      end
      BK_PDEX: begin
        do_put  = 1'b1;
        put_val = 13'(16'(bd) - dist_base(dist_idx));
        put_n   = dist_extra(dist_idx);
        st_next = BK_FLUSH;
      end
      BK_PLIT: begin
        sb      = sym_code({1'b0, b0});
        do_put  = 1'b1;
        put_val = 13'(sb.code);
        put_n   = sb.nbits;
        st_next = BK_FLUSH;
      end
      BK_PEOB: begin
        // end-of-block is seven zero bits
        do_put  = 1'b1;
        put_n   = 4'd7;
        st_next = BK_FLUSH;
      end
      BK_FLUSH: begin
        if (cnt >= CNT_W'(8)) begin
          out_push = !out_full;
          out_word = '{data: acc[7:0], last: pad && (cnt == CNT_W'(8))};
        end else if (pad) begin
          if (cnt != '0) begin
            out_push = !out_full;
            out_word = '{data: acc[7:0], last: 1'b1};
            if (!out_full) st_next = BK_IDLE;
          end else begin
            st_next = BK_IDLE;
          end
        end else begin
          st_next = BK_ICHK;
        end
      end
      BK_ICHK: if ((ins_left == 9'd0) || ins_end) st_next = BK_IDLE;
               else st_next = BK_IHEAD;
      BK_IHEAD: begin
        rd_a_pos = q + 32'd3;
        st_next  = BK_IWR;
      end
      BK_IWR:   st_next = BK_ICHK;
      default:  st_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epos     <= '0;
      done     <= 1'b0;
      acc      <= ACC_W'(3);
      cnt      <= CNT_W'(3);
      clr_addr <= '0;
      pad      <= 1'b0;
    end else begin
      if (do_put) begin
        acc <= acc | (ACC_W'(put_val) << cnt);
        cnt <= cnt + CNT_W'(put_n);
      end
      case (st)
        BK_CLEAR: clr_addr <= clr_addr + 1'b1;
        BK_IDLE: begin
          stop <= cmd_word.stop_pos;
          pad  <= 1'b0;
        end
        BK_RD1: begin
          b0 <= hist_data_a;
          b1 <= hist_data_b;
        end
        BK_RD2: begin
          b2   <= hist_data_a;
          maxl <= (rem > 32'(MAX_MATCH)) ? MAX_MATCH : rem[8:0];
          best <= '0;
          bd   <= '0;
        end
        BK_HASH: h <= prod[31 -: HASH_BITS];
        BK_HEADQ: begin
          ok    <= head_rdata[32];
          cand  <= head_rdata[31:0];
          chain <= '0;
        end
        BK_WCHK: mlen <= '0;
        BK_WPRE: mlen <= '0;
        BK_WCMP: begin
          if (eq && (ln1 < maxl)) begin
            mlen <= ln1;
          end else if (take_best) begin
            best <= cmp_len;
            bd   <= d_cur[DW-1:0];
          end
        end
        BK_WLINK: begin
          ok    <= link_rdata[32];
          cand  <= link_rdata[31:0];
          chain <= chain + 8'd1;
        end
        BK_DEC: begin
          len_idx  <= len_index(best);
          dist_idx <= dist_index(16'(bd));
          q        <= epos;
          ins_left <= is_match ? best : 9'd1;
        end
        BK_PLEN: epos <= epos + 32'(best);
        BK_PLIT: epos <= epos + 32'd1;
        BK_PEOB: pad  <= 1'b1;
        BK_FLUSH: begin
          if (cnt >= CNT_W'(8)) begin
            if (!out_full) begin
              acc <= acc >> 8;
              cnt <= cnt - CNT_W'(8);
              if (pad && (cnt == CNT_W'(8))) done <= 1'b1;
            end
          end else if (pad) begin
            if (cnt == '0) begin
              done <= 1'b1;
            end else if (!out_full) begin
              acc  <= '0;
              cnt  <= '0;
              done <= 1'b1;
            end
          end
        end
        BK_ICHK: h <= prod[31 -: HASH_BITS];
        BK_IWR: begin
          b0       <= b1;
          b1       <= b2;
          b2       <= hist_data_a;
          q        <= q + 32'd1;
          ins_left <= ins_left - 9'd1;
        end
        default: ;
      endcase
    end
  end

  `DFHC_ASSERT(a_cnt_idle, (st == BK_IDLE) |-> (cnt < CNT_W'(8)), "bits left over at idle")
  `DFHC_ASSERT(a_done_sticky, done |=> done, "stream done flag dropped")
  `DFHC_ASSERT(a_best_bound, (st == BK_DEC) |-> (best <= maxl), "match longer than allowed")
  `DFHC_ASSERT(a_out_room, out_push |-> !out_full, "word pushed into full output queue")
  `DFHC_ASSERT(a_cmp_bound, (st == BK_WCMP) |-> (mlen < maxl), "compare past match limit")
endmodule
`default_nettype wire

// ----- rtl/deflate_fixed_huffman_compressor_unit.sv -----
// Fixed Huffman DEFLATE compressor, one final block per stream. A byte push
// that leaves fewer than 260 bytes of lookahead only stores the byte; a push
// or drain that codes a token walks the hash chain, comparing each candidate
// byte by byte (up to 258 bytes), then codes a literal or a match, inserts
// the coded positions into the hash chains and writes out the output bytes.
// The chain walk and byte compare over the history memory set the time per
// token; the command queue lets pushes run ahead of them.
// After reset, full stays high while the hash head table is cleared;
// configuration writes still work.
// Depends on dfhc_pkg, dfhc_ram, dfhc_fifo, dfhc_front and dfhc_back.
`default_nettype none
module deflate_fixed_huffman_compressor_unit #(
  parameter int WINDOW_SIZE   = dfhc_pkg::WINDOW_SIZE_DEF,
  parameter int HASH_BITS     = dfhc_pkg::HASH_BITS_DEF,
  parameter int HISTORY_DEPTH = dfhc_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           command,
  input  wire logic [7:0]                     data_byte,
  output logic                                empty,
  input  wire logic                           pop,
  output logic      [7:0]                     out_byte,
  output logic                                last_byte,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dfhc_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);
  import dfhc_pkg::*;

  localparam int HAW = $clog2(HISTORY_DEPTH);

  logic [7:0]  chain_limit;
  logic [15:0] short_dist;
  logic        cfg_wr;

  cmd_t      q_in, q_out;
  logic      q_push, q_full, q_pop, q_empty;
  out_word_t o_in, o_out;
  logic      o_push, o_full;
  logic      clearing;

  logic           hist_we;
  logic [HAW-1:0] hist_waddr, hist_addr_a, hist_addr_b;
  logic [7:0]     hist_wdata, hist_data_a, hist_data_b;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_SHORT_DIST) ? {16'd0, short_dist} : {24'd0, chain_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_limit <= CHAIN_LIMIT_RST;
      short_dist  <= SHORT_DIST_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_CHAIN_LIMIT) chain_limit <= pwdata[7:0];
      else                             short_dist  <= pwdata[15:0];
    end
  end

  dfhc_front #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .data_byte(data_byte), .clearing(clearing), .q_word(q_in), .q_push(q_push),
    .q_full(q_full), .hist_we(hist_we), .hist_waddr(hist_waddr),
    .hist_wdata(hist_wdata)
  );

  dfhc_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CMD_FIFO_DEPTH)) u_cmd_q (
    .clk(clk), .rst(rst), .push(q_push), .wdata(q_in), .full(q_full),
    .pop(q_pop), .rdata(q_out), .empty(q_empty)
  );

  // two copies so the compare reads a byte of each string in the same cycle
  dfhc_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist_a (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(hist_addr_a), .rdata(hist_data_a)
  );

  dfhc_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist_b (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(hist_addr_b), .rdata(hist_data_b)
  );

  dfhc_back #(
    .WINDOW_SIZE(WINDOW_SIZE), .HASH_BITS(HASH_BITS), .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_back (
    .clk(clk), .rst(rst), .cmd_word(q_out), .cmd_empty(q_empty), .cmd_pop(q_pop),
    .hist_addr_a(hist_addr_a), .hist_addr_b(hist_addr_b),
    .hist_data_a(hist_data_a), .hist_data_b(hist_data_b),
    .chain_limit(chain_limit), .short_dist(short_dist),
    .out_push(o_push), .out_word(o_in), .out_full(o_full), .clearing(clearing)
  );

  dfhc_fifo #(.WIDTH($bits(out_word_t)), .DEPTH(OUT_FIFO_DEPTH)) u_out_q (
    .clk(clk), .rst(rst), .push(o_push), .wdata(o_in), .full(o_full),
    .pop(pop), .rdata(o_out), .empty(empty)
  );

  assign out_byte  = o_out.data;
  assign last_byte = o_out.last;
endmodule
`default_nettype wire
